FILE: src/stepped_carrier_scan_detector_unit_defines.svh
`ifndef STEPPED_CARRIER_SCAN_DETECTOR_UNIT_DEFINES_SVH
`define STEPPED_CARRIER_SCAN_DETECTOR_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SCSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define SCSD_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: src/scsd_pkg.sv
package scsd_pkg;

	localparam int STEP_W   = 7;
	localparam int TOTAL_W  = 8;
	localparam int BLK_MAX  = 1024;
	localparam int CNT_W    = 11;
	localparam int SUM_W    = 26;
	localparam int SQ_W     = 44;
	localparam int DIV_W    = 44;
	localparam int V_W      = 46;
	localparam int NSUM_W   = 39;
	localparam int OUT_W    = 152;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_RESCAN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd4;

	typedef logic [4:0] cmd_t;

	localparam cmd_t CMD_NONE       = 5'd0;
	localparam cmd_t CMD_SAMPLE     = 5'd1;
	localparam cmd_t CMD_TICK       = 5'd2;
	localparam cmd_t CMD_START      = 5'd3;
	localparam cmd_t CMD_DIV_STEPS  = 5'd4;
	localparam cmd_t CMD_TAKE_STEPS = 5'd5;
	localparam cmd_t CMD_DIV_MI     = 5'd6;
	localparam cmd_t CMD_TAKE_MI    = 5'd7;
	localparam cmd_t CMD_DIV_MQ     = 5'd8;
	localparam cmd_t CMD_TAKE_MQ    = 5'd9;
	localparam cmd_t CMD_MUL_A      = 5'd10;
	localparam cmd_t CMD_MUL_B      = 5'd11;
	localparam cmd_t CMD_MUL_C      = 5'd12;
	localparam cmd_t CMD_MUL_D      = 5'd13;
	localparam cmd_t CMD_MUL_E      = 5'd14;
	localparam cmd_t CMD_MUL_F      = 5'd15;
	localparam cmd_t CMD_MUL_G      = 5'd16;
	localparam cmd_t CMD_DIV_VAR    = 5'd17;
	localparam cmd_t CMD_TAKE_VAR   = 5'd18;
	localparam cmd_t CMD_DIV_AVG    = 5'd19;
	localparam cmd_t CMD_TAKE_AVG   = 5'd20;
	localparam cmd_t CMD_MUL_STEP   = 5'd21;
	localparam cmd_t CMD_SET_LO     = 5'd22;
	localparam cmd_t CMD_DIV_NOISE  = 5'd23;
	localparam cmd_t CMD_TAKE_NOISE = 5'd24;
	localparam cmd_t CMD_DECIDE     = 5'd25;
	localparam cmd_t CMD_FINISH     = 5'd26;
	localparam cmd_t CMD_OUT        = 5'd27;

	typedef struct packed {
		logic [1:0] op;
		logic       scanning;
		logic       blk_end;
		logic       last;
		logic       restart_ok;
		logic       steps_div;
		logic       div_done;
		logic       dwell_reached;
		logic       more_steps;
		logic       noise_zero;
		logic       out_free;
	} stat_t;

endpackage

FILE: src/scsd_div.sv
module scsd_div import scsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      dsr_q;
	logic [DIV_W-1:0] quo_q;
	logic [32:0]      shifted;
	logic [32:0]      diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[31:0] : shifted[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/scsd_datapath.sv
module scsd_datapath import scsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_accept,
	input  logic [1:0]           in_opcode,
	input  logic [15:0]          in_i,
	input  logic [15:0]          in_q,
	input  logic                 in_last,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     out_data
);

	logic [31:0] start_hz_q, stop_hz_q, step_hz_q;
	logic [15:0] dwell_cfg_q, delay_q;

	logic              scanning_q;
	logic [STEP_W-1:0] pos_q, bpos_q;
	logic [TOTAL_W-1:0] total_q;
	logic [15:0]       dwell_q, idle_q;
	logic [31:0]       accum_q, best_q, noise_q, lo_q, est_q;
	logic              carrier_q, upd_q;
	logic [SUM_W-1:0]  sum_i_q, sum_q_q;
	logic [SQ_W-1:0]   sum_sq_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NSUM_W-1:0] sum_all_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [1:0]        op_q;
	logic [15:0]       iv_q, qv_q;
	logic              last_q;
	logic [15:0]       mi_q, mq_q;
	logic [V_W-1:0]    p_q, v_q;

	logic [31:0]       isq, qsq;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       mul_prod;
	logic              div_start, div_done;
	logic [DIV_W-1:0]  div_dividend, div_quot;
	logic [31:0]       div_divisor;
	logic [15:0]       need;
	logic [31:0]       metric;
	logic [32:0]       acc_sum;
	logic [31:0]       avg;
	logic [33:0]       best2, noise3;
	logic              carrier_next;
	logic [NSUM_W-1:0] rest_sum;

	assign isq      = iv_q * iv_q;
	assign qsq      = qv_q * qv_q;
	assign need     = (dwell_cfg_q == 16'd0) ? 16'd1 : dwell_cfg_q;
	assign metric   = (|div_quot[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
	assign acc_sum  = {1'b0, accum_q} + {1'b0, metric};
	assign avg      = div_quot[31:0];
	assign best2    = {1'b0, best_q, 1'b0};
	assign noise3   = {2'b00, noise_q} + {1'b0, noise_q, 1'b0};
	assign carrier_next = ((noise_q == 32'd0) && (best_q != 32'd0)) || (best2 > noise3);
	assign rest_sum = sum_all_q - {7'd0, best_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			CMD_MUL_A: begin
				mul_a = {16'd0, mi_q};
				mul_b = {16'd0, mi_q};
			end
			CMD_MUL_B, CMD_MUL_E: begin
				mul_a = p_q[31:0];
				mul_b = {21'd0, cnt_q};
			end
			CMD_MUL_C: begin
				mul_a = {16'd0, mi_q};
				mul_b = {6'd0, sum_i_q};
			end
			CMD_MUL_D: begin
				mul_a = {16'd0, mq_q};
				mul_b = {16'd0, mq_q};
			end
			CMD_MUL_F: begin
				mul_a = {16'd0, mq_q};
				mul_b = {6'd0, sum_q_q};
			end
			CMD_MUL_STEP: begin
				mul_a = {25'd0, pos_q};
				mul_b = step_hz_q;
			end
			CMD_DECIDE: begin
				mul_a = {25'd0, bpos_q};
				mul_b = step_hz_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;

	always_comb begin
		div_start    = 1'b1;
		div_dividend = '0;
		div_divisor  = 32'd1;
		case (cmd)
			CMD_DIV_STEPS: begin
				div_dividend = {12'd0, stop_hz_q - start_hz_q};
				div_divisor  = step_hz_q;
			end
			CMD_DIV_MI: begin
				div_dividend = {18'd0, sum_i_q};
				div_divisor  = {21'd0, cnt_q};
			end
			CMD_DIV_MQ: begin
				div_dividend = {18'd0, sum_q_q};
				div_divisor  = {21'd0, cnt_q};
			end
			CMD_DIV_VAR: begin
				div_dividend = v_q[DIV_W-1:0];
				div_divisor  = {21'd0, cnt_q};
			end
			CMD_DIV_AVG: begin
				div_dividend = {12'd0, accum_q};
				div_divisor  = {16'd0, dwell_q};
			end
			CMD_DIV_NOISE: begin
				div_dividend = {5'd0, rest_sum};
				div_divisor  = {24'd0, total_q - 8'd1};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	scsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hz_q  <= '0;
			stop_hz_q   <= '0;
			step_hz_q   <= '0;
			dwell_cfg_q <= 16'd1;
			delay_q     <= 16'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START: start_hz_q  <= cfg_data;
				REG_STOP:  stop_hz_q   <= cfg_data;
				REG_STEP:  step_hz_q   <= cfg_data;
				REG_DWELL: dwell_cfg_q <= cfg_data[15:0];
				REG_DELAY: delay_q     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q  <= 1'b1;
			pos_q       <= '0;
			bpos_q      <= '0;
			total_q     <= 8'd1;
			dwell_q     <= '0;
			idle_q      <= '0;
			accum_q     <= '0;
			best_q      <= '0;
			noise_q     <= '0;
			lo_q        <= '0;
			est_q       <= '0;
			carrier_q   <= 1'b0;
			upd_q       <= 1'b0;
			sum_i_q     <= '0;
			sum_q_q     <= '0;
			sum_sq_q    <= '0;
			cnt_q       <= '0;
			sum_all_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				upd_q <= 1'b0;
			end
			if (cmd == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_SAMPLE: begin
					sum_i_q  <= sum_i_q + {10'd0, iv_q};
					sum_q_q  <= sum_q_q + {10'd0, qv_q};
					sum_sq_q <= sum_sq_q + {12'd0, isq} + {12'd0, qsq};
					cnt_q    <= cnt_q + 11'd1;
				end
				CMD_TICK: begin
					if (!scanning_q && (idle_q != 16'hFFFF)) begin
						idle_q <= idle_q + 16'd1;
					end
				end
				CMD_START: begin
					scanning_q <= 1'b1;
					pos_q      <= '0;
					bpos_q     <= '0;
					total_q    <= 8'd1;
					dwell_q    <= '0;
					idle_q     <= '0;
					accum_q    <= '0;
					best_q     <= '0;
					noise_q    <= '0;
					lo_q       <= start_hz_q;
					est_q      <= start_hz_q;
					carrier_q  <= 1'b0;
					upd_q      <= 1'b1;
					sum_i_q    <= '0;
					sum_q_q    <= '0;
					sum_sq_q   <= '0;
					cnt_q      <= '0;
					sum_all_q  <= '0;
				end
				CMD_TAKE_STEPS: begin
					total_q <= (div_quot >= 44'd127) ? 8'd128 : {1'b0, div_quot[6:0]} + 8'd1;
				end
				CMD_TAKE_VAR: begin
					accum_q  <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
					dwell_q  <= dwell_q + 16'd1;
					sum_i_q  <= '0;
					sum_q_q  <= '0;
					sum_sq_q <= '0;
					cnt_q    <= '0;
				end
				CMD_TAKE_AVG: begin
					sum_all_q <= sum_all_q + {7'd0, avg};
					if (avg > best_q) begin
						best_q <= avg;
						bpos_q <= pos_q;
					end
					accum_q <= '0;
					dwell_q <= '0;
					upd_q   <= 1'b1;
					if (stat.more_steps) begin
						pos_q <= pos_q + 7'd1;
					end
				end
				CMD_SET_LO: begin
					lo_q <= start_hz_q + p_q[31:0];
				end
				CMD_TAKE_NOISE: begin
					noise_q <= div_quot[31:0];
				end
				CMD_DECIDE: begin
					carrier_q <= carrier_next;
				end
				CMD_FINISH: begin
					lo_q       <= start_hz_q + p_q[31:0];
					est_q      <= start_hz_q + p_q[31:0];
					scanning_q <= 1'b0;
					idle_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= in_opcode;
			iv_q   <= in_i;
			qv_q   <= in_q;
			last_q <= in_last;
		end
		if (cmd == CMD_TAKE_MI) begin
			mi_q <= div_quot[15:0];
		end
		if (cmd == CMD_TAKE_MQ) begin
			mq_q <= div_quot[15:0];
		end
		case (cmd)
			CMD_MUL_A: begin
				p_q <= mul_prod[V_W-1:0];
				v_q <= {2'd0, sum_sq_q};
			end
			CMD_MUL_B, CMD_MUL_E, CMD_MUL_STEP, CMD_DECIDE: begin
				p_q <= mul_prod[V_W-1:0];
			end
			CMD_MUL_C, CMD_MUL_F: begin
				p_q <= mul_prod[V_W-1:0];
				v_q <= v_q + p_q;
			end
			CMD_MUL_D: begin
				p_q <= mul_prod[V_W-1:0];
				v_q <= v_q - {p_q[V_W-2:0], 1'b0};
			end
			CMD_MUL_G: begin
				v_q <= v_q - {p_q[V_W-2:0], 1'b0};
			end
			default: begin
			end
		endcase
		if (cmd == CMD_OUT) begin
			out_data_q <= {6'd0, total_q, pos_q, noise_q, best_q, est_q,
				carrier_q, scanning_q, upd_q, lo_q};
		end
	end

	assign stat.op            = op_q;
	assign stat.scanning      = scanning_q;
	assign stat.blk_end       = last_q || (cnt_q == 11'(BLK_MAX - 1));
	assign stat.last          = last_q;
	assign stat.restart_ok    = idle_q >= delay_q;
	assign stat.steps_div     = (step_hz_q != 32'd0) && (stop_hz_q >= start_hz_q);
	assign stat.div_done      = div_done;
	assign stat.dwell_reached = dwell_q >= need;
	assign stat.more_steps    = ({1'b0, pos_q} + 8'd1) < total_q;
	assign stat.noise_zero    = total_q == 8'd1;
	assign stat.out_free      = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: src/scsd_ctrl.sv
`include "stepped_carrier_scan_detector_unit_defines.svh"

module scsd_ctrl import scsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_DISP     = 5'd1;
	localparam logic [4:0] ST_STEPS    = 5'd2;
	localparam logic [4:0] ST_W_STEPS  = 5'd3;
	localparam logic [4:0] ST_DIV_MI   = 5'd4;
	localparam logic [4:0] ST_W_MI     = 5'd5;
	localparam logic [4:0] ST_DIV_MQ   = 5'd6;
	localparam logic [4:0] ST_W_MQ     = 5'd7;
	localparam logic [4:0] ST_MA       = 5'd8;
	localparam logic [4:0] ST_MB       = 5'd9;
	localparam logic [4:0] ST_MC       = 5'd10;
	localparam logic [4:0] ST_MD       = 5'd11;
	localparam logic [4:0] ST_ME       = 5'd12;
	localparam logic [4:0] ST_MF       = 5'd13;
	localparam logic [4:0] ST_MG       = 5'd14;
	localparam logic [4:0] ST_DIV_VAR  = 5'd15;
	localparam logic [4:0] ST_W_VAR    = 5'd16;
	localparam logic [4:0] ST_CHK      = 5'd17;
	localparam logic [4:0] ST_W_AVG    = 5'd18;
	localparam logic [4:0] ST_MUL_STEP = 5'd19;
	localparam logic [4:0] ST_SET_LO   = 5'd20;
	localparam logic [4:0] ST_NOISE    = 5'd21;
	localparam logic [4:0] ST_W_NOISE  = 5'd22;
	localparam logic [4:0] ST_DECIDE   = 5'd23;
	localparam logic [4:0] ST_FINISH   = 5'd24;
	localparam logic [4:0] ST_OUT      = 5'd25;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				state_d = ST_OUT;
				case (stat.op)
					OP_SAMPLE: begin
						if (stat.scanning) begin
							cmd = CMD_SAMPLE;
							if (stat.blk_end) begin
								state_d = ST_DIV_MI;
							end
						end else if (stat.last && stat.restart_ok) begin
							cmd     = CMD_START;
							state_d = ST_STEPS;
						end
					end
					OP_TICK: begin
						cmd = CMD_TICK;
					end
					OP_RESCAN: begin
						cmd     = CMD_START;
						state_d = ST_STEPS;
					end
					default: begin
					end
				endcase
			end
			ST_STEPS: begin
				if (stat.steps_div) begin
					cmd     = CMD_DIV_STEPS;
					state_d = ST_W_STEPS;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_W_STEPS: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_STEPS;
					state_d = ST_OUT;
				end
			end
			ST_DIV_MI: begin
				cmd     = CMD_DIV_MI;
				state_d = ST_W_MI;
			end
			ST_W_MI: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_MI;
					state_d = ST_DIV_MQ;
				end
			end
			ST_DIV_MQ: begin
				cmd     = CMD_DIV_MQ;
				state_d = ST_W_MQ;
			end
			ST_W_MQ: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_MQ;
					state_d = ST_MA;
				end
			end
			ST_MA: begin
				cmd     = CMD_MUL_A;
				state_d = ST_MB;
			end
			ST_MB: begin
				cmd     = CMD_MUL_B;
				state_d = ST_MC;
			end
			ST_MC: begin
				cmd     = CMD_MUL_C;
				state_d = ST_MD;
			end
			ST_MD: begin
				cmd     = CMD_MUL_D;
				state_d = ST_ME;
			end
			ST_ME: begin
				cmd     = CMD_MUL_E;
				state_d = ST_MF;
			end
			ST_MF: begin
				cmd     = CMD_MUL_F;
				state_d = ST_MG;
			end
			ST_MG: begin
				cmd     = CMD_MUL_G;
				state_d = ST_DIV_VAR;
			end
			ST_DIV_VAR: begin
				cmd     = CMD_DIV_VAR;
				state_d = ST_W_VAR;
			end
			ST_W_VAR: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_VAR;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.dwell_reached) begin
					cmd     = CMD_DIV_AVG;
					state_d = ST_W_AVG;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_W_AVG: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_AVG;
					state_d = stat.more_steps ? ST_MUL_STEP : ST_NOISE;
				end
			end
			ST_MUL_STEP: begin
				cmd     = CMD_MUL_STEP;
				state_d = ST_SET_LO;
			end
			ST_SET_LO: begin
				cmd     = CMD_SET_LO;
				state_d = ST_OUT;
			end
			ST_NOISE: begin
				if (stat.noise_zero) begin
					state_d = ST_DECIDE;
				end else begin
					cmd     = CMD_DIV_NOISE;
					state_d = ST_W_NOISE;
				end
			end
			ST_W_NOISE: begin
				if (stat.div_done) begin
					cmd     = CMD_TAKE_NOISE;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd     = CMD_DECIDE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd     = CMD_FINISH;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd     = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;

	`SCSD_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_q == ST_DISP, "accepted request not dispatched")
	`SCSD_ASSERT(a_out_free, (cmd == CMD_OUT) |-> stat.out_free, "result written over a pending one")
	`SCSD_ASSERT(a_div_expected, stat.div_done |-> (state_q == ST_W_STEPS || state_q == ST_W_MI || state_q == ST_W_MQ || state_q == ST_W_VAR || state_q == ST_W_AVG || state_q == ST_W_NOISE), "divider finished outside a wait state")
	`SCSD_ASSERT_NEXT(a_out_to_idle, cmd == CMD_OUT, in_ready, "controller did not return to idle after a result")

endmodule

FILE: src/stepped_carrier_scan_detector_unit.sv
// Stepped-frequency carrier scan detector. Each accepted request is handled to
// completion before the next is taken. A tick, an unused opcode, an idle sample or a
// sample that does not close a block goes from dispatch straight to the result. A
// rescan, or an idle sample that restarts the scan, also divides for the step count
// unless the step is zero or the stop lies below the start. A sample closing a block
// divides for both block means and the block variance, one that also closes a step
// for the step average too, and one that closes a scan of more than one step for the
// noise level as well. The single restoring divider serves the step count, both block
// means, the block variance, the step average and the noise level in turn. The result
// register lets the next request be accepted while a result still waits.
module stepped_carrier_scan_detector_unit import scsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // i_sample, q_sample
	input  logic [1:0]           s_axis_tuser,  // opcode
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// LO frequency, LO update flag, scan active flag, carrier flag,
	// carrier frequency estimate, peak step metric, noise level, current step, step count
	output logic [OUT_W-1:0]     m_axis_tdata
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_accept;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	scsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scsd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_opcode (s_axis_tuser),
		.in_i      (s_axis_tdata[15:0]),
		.in_q      (s_axis_tdata[31:16]),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: verif/testbench.sv
module testbench;
	import scsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct packed {
		logic [31:0] lo;
		logic        upd;
		logic        act;
		logic        car;
		logic [31:0] est;
		logic [31:0] best;
		logic [31:0] noise;
		logic [6:0]  step;
		logic [7:0]  total;
	} scan_status_t;

	typedef struct {
		logic [1:0]   op;
		logic [15:0]  i_s;
		logic [15:0]  q_s;
		logic         last;
		bit           typed;
		scan_status_t exp;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;

	stepped_carrier_scan_detector_unit dut (.*);

	bit [31:0] r_start, r_stop, r_step, r_dwell, r_delay;
	bit        p_scanning, p_carrier;
	bit [31:0] p_pos, p_total, p_dwell_cnt, p_accum;
	bit [63:0] p_sum_i, p_sum_q, p_sum_sq;
	bit [31:0] p_count;
	bit [31:0] p_store [128];
	bit [31:0] p_best, p_best_pos, p_noise, p_lo, p_est, p_idle;

	scan_status_t status_q [$];
	int  errors = 0;
	int  quiet_cycles = 0;
	bit  gaps_on;
	int  rx_stall = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [31:0] steps_for_config();
		bit [63:0] n;
		if (r_step == 0 || r_stop < r_start)
			return 1;
		n = 64'(r_stop - r_start) / 64'(r_step) + 1;
		if (n > 128)
			n = 128;
		return n[31:0];
	endfunction

	function automatic bit [31:0] step_frequency(bit [31:0] idx);
		return r_start + idx * r_step;
	endfunction

	task automatic clear_block_sums();
		p_sum_i = 0;
		p_sum_q = 0;
		p_sum_sq = 0;
		p_count = 0;
	endtask

	task automatic begin_scan();
		foreach (p_store[k])
			p_store[k] = 0;
		p_accum = 0;
		p_dwell_cnt = 0;
		p_best_pos = 0;
		p_scanning = 1;
		p_carrier = 0;
		p_lo = r_start;
		p_est = r_start;
		p_best = 0;
		p_noise = 0;
		p_pos = 0;
		p_total = steps_for_config();
		p_idle = 0;
		clear_block_sums();
	endtask

	function automatic bit [31:0] block_variance();
		bit [63:0] n, mi, mq, v;
		n = 64'(p_count);
		if (n == 0)
			return 0;
		mi = p_sum_i / n;
		mq = p_sum_q / n;
		v = p_sum_sq - 2 * mi * p_sum_i + n * mi * mi - 2 * mq * p_sum_q + n * mq * mq;
		v = v / n;
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	task automatic end_scan();
		bit [63:0] sum;
		bit [31:0] cnt;
		sum = 0;
		cnt = 0;
		for (int k = 0; k < p_total && k < 128; k++) begin
			if (k != p_best_pos) begin
				sum += p_store[k];
				cnt++;
			end
		end
		p_noise = (cnt == 0) ? 0 : 32'(sum / cnt);
		if (p_noise == 0 && p_best > 0)
			p_carrier = 1;
		else
			p_carrier = (64'(p_best) * 2) > (64'(p_noise) * 3);
		p_est = step_frequency(p_best_pos);
		p_lo = p_est;
		p_scanning = 0;
		p_idle = 0;
	endtask

	task automatic close_block(output bit retuned);
		bit [31:0] m, need, avg;
		m = block_variance();
		need = (r_dwell == 0) ? 1 : r_dwell;
		retuned = 0;
		clear_block_sums();
		p_accum = (m > 32'hFFFF_FFFF - p_accum) ? 32'hFFFF_FFFF : p_accum + m;
		p_dwell_cnt++;
		if (p_dwell_cnt >= need) begin
			avg = p_accum / p_dwell_cnt;
			if (p_pos < 128)
				p_store[p_pos] = avg;
			if (avg > p_best) begin
				p_best = avg;
				p_best_pos = p_pos;
			end
			p_accum = 0;
			p_dwell_cnt = 0;
			if (p_pos + 1 < p_total) begin
				p_pos++;
				p_lo = step_frequency(p_pos);
			end else begin
				end_scan();
			end
			retuned = 1;
		end
	endtask

	task automatic predict_status(input logic [1:0] op, input logic [15:0] iv,
			input logic [15:0] qv, input logic last, output scan_status_t st);
		bit upd;
		upd = 0;
		if (op == OP_SAMPLE) begin
			if (p_scanning) begin
				p_sum_i += iv;
				p_sum_q += qv;
				p_sum_sq += 64'(iv) * 64'(iv) + 64'(qv) * 64'(qv);
				p_count++;
				if (last || p_count >= BLK_MAX)
					close_block(upd);
			end else if (last && p_idle >= r_delay) begin
				begin_scan();
				upd = 1;
			end
		end else if (op == OP_TICK) begin
			if (!p_scanning && p_idle < 32'hFFFF)
				p_idle++;
		end else if (op == OP_RESCAN) begin
			begin_scan();
			upd = 1;
		end
		st = '{p_lo, upd, p_scanning, p_carrier, p_est, p_best, p_noise,
			p_pos[6:0], p_total[7:0]};
	endtask

	function automatic scan_status_t unpack_status(logic [OUT_W-1:0] d);
		scan_status_t st;
		st.lo = d[31:0];
		st.upd = d[32];
		st.act = d[33];
		st.car = d[34];
		st.est = d[66:35];
		st.best = d[98:67];
		st.noise = d[130:99];
		st.step = d[137:131];
		st.total = d[145:138];
		return st;
	endfunction

	always @(posedge clk) begin
		scan_status_t got, want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[stepped_carrier_scan_detector_unit] ERROR");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = unpack_status(m_axis_tdata);
			if (status_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: %p", got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rx_stall <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_request(logic [1:0] op, logic [15:0] iv, logic [15:0] qv,
			logic last, bit typed = 0, scan_status_t typed_exp = '{default: 0});
		scan_status_t st;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {qv, iv};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_status(op, iv, qv, last, st);
		status_q.push_back(typed ? typed_exp : st);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		wait (status_q.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_config(bit [31:0] start_hz, bit [31:0] stop_hz, bit [31:0] step_hz,
			bit [31:0] dwell, bit [31:0] delay);
		bit [31:0] vals [5];
		vals = '{start_hz, stop_hz, step_hz, dwell, delay};
		for (int k = 0; k < 5; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		r_start = start_hz;
		r_stop = stop_hz;
		r_step = step_hz;
		r_dwell = dwell & 32'hFFFF;
		r_delay = delay & 32'hFFFF;
	endtask

	function automatic logic [15:0] adc_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_traffic(int n, int max_len, bit noisy);
		int blk_len, blk_pos, r;
		blk_len = $urandom_range(1, max_len);
		blk_pos = 0;
		for (int k = 0; k < n; k++) begin
			r = noisy ? $urandom_range(0, 39) : 39;
			if (r == 0) begin
				send_request(OP_RESCAN, adc_value(), adc_value(), 1'($urandom));
				blk_pos = 0;
			end else if (r <= 4) begin
				send_request(OP_TICK, adc_value(), adc_value(), 1'($urandom));
			end else if (r == 5) begin
				send_request(OP_NOP, adc_value(), adc_value(), 1'($urandom));
			end else if (r == 6) begin
				send_request(OP_SAMPLE, adc_value(), adc_value(), 1'($urandom));
				blk_pos = 0;
			end else begin
				blk_pos++;
				send_request(OP_SAMPLE, adc_value(), adc_value(), blk_pos >= blk_len);
				if (blk_pos >= blk_len) begin
					blk_pos = 0;
					blk_len = $urandom_range(1, max_len);
				end
			end
		end
	endtask

	initial begin
		dir_row_t rows [14];
		bit [31:0] st, sp;
		rows = '{
			'{OP_TICK,   16'h0000, 16'h0000, 1'b0, 1, '{0, 0, 1, 0, 0, 0, 0, 0, 1}},
			'{OP_RESCAN, 16'h0000, 16'h0000, 1'b0, 1, '{0, 1, 1, 0, 0, 0, 0, 0, 1}},
			'{OP_NOP,    16'hFFFF, 16'hFFFF, 1'b1, 1, '{0, 0, 1, 0, 0, 0, 0, 0, 1}},
			'{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1, 1, '{0, 1, 0, 0, 0, 0, 0, 0, 1}},
			'{OP_TICK,   16'h0000, 16'h0000, 1'b0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1}},
			'{OP_SAMPLE, 16'h0000, 16'h0000, 1'b1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1}},
			'{OP_RESCAN, 16'h0000, 16'h0000, 1'b0, 1, '{0, 1, 1, 0, 0, 0, 0, 0, 1}},
			'{OP_SAMPLE, 16'h0000, 16'h0000, 1'b0, 0, '{default: 0}},
			'{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1, 0, '{default: 0}},
			'{OP_RESCAN, 16'h1234, 16'h5678, 1'b1, 0, '{default: 0}},
			'{OP_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, 0, '{default: 0}},
			'{OP_SAMPLE, 16'h0000, 16'hFFFF, 1'b1, 0, '{default: 0}},
			'{OP_NOP,    16'hA5A5, 16'h5A5A, 1'b0, 0, '{default: 0}},
			'{OP_TICK,   16'hFFFF, 16'h0000, 1'b1, 0, '{default: 0}}
		};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		gaps_on = 1;
		r_start = 0;
		r_stop = 0;
		r_step = 0;
		r_dwell = 1;
		r_delay = 3000;
		begin_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[k])
			send_request(rows[k].op, rows[k].i_s, rows[k].q_s, rows[k].last,
				rows[k].typed, rows[k].exp);

		for (int p = 0; p < 10; p++) begin
			drain_results();
			case (p)
				0: write_config(1000, 2250, 250, 1, 0);
				1: write_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 2);
				2: write_config(0, 32'hFFFF_FFFF, 1, 1, 65535);
				3: write_config(50, 40, 7, 0, 1);
				8: write_config(32'hFFFF_FFFF, 0, 32'h8000_0000, 65535, 3);
				default: begin
					st = $urandom;
					sp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 20);
					write_config(st, st + sp * $urandom_range(0, 7), sp,
						$urandom_range(0, 3), $urandom_range(0, 4));
				end
			endcase
			gaps_on = (p != 9);
			send_request(OP_RESCAN, adc_value(), adc_value(), 1'($urandom));
			case (p)
				2: run_traffic(140, 1, 0);
				default: run_traffic(70, 6, 1);
			endcase
		end

		s_axis_tvalid <= 1'b0;
		wait (status_q.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && status_q.size() == 0)
			$display("[stepped_carrier_scan_detector_unit] OK");
		else
			$display("[stepped_carrier_scan_detector_unit] ERROR");
		$finish;
	end

endmodule
